[design/eida_pkg.sv]
// eida_pkg: shared types, codes and widths of the entity id allocator
// depends on: nothing

package eida_pkg;

    // fixed widths of the transaction fields
    localparam int CMD_W      = 3;
    localparam int ID_PORT_W  = 10;
    localparam int QMASK_W    = 8;
    localparam int COMP_W     = 3;
    localparam int CNT_PORT_W = 11;

    // default sizing of the id space and component kinds
    localparam int MAX_ENTITIES_DEF    = 1024;
    localparam int COMPONENT_KINDS_DEF = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NONE_LEFT,
        ST_BAD_ID,
        ST_STACK_FULL
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

[design/eida_req_if.sv]
// eida_req_if: request channel of the entity id allocator
// depends on: eida_pkg

interface eida_req_if import eida_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_PORT_W-1:0] entity_id;
    logic [QMASK_W-1:0] query_mask;
    logic [COMP_W-1:0]  component_index;

    modport source (output valid, output cmd, output entity_id, output query_mask,
                    output component_index, input ready);
    modport sink   (input valid, input cmd, input entity_id, input query_mask,
                    input component_index, output ready);
endinterface

[design/eida_rsp_if.sv]
// eida_rsp_if: result channel of the entity id allocator
// depends on: eida_pkg

interface eida_rsp_if import eida_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [ID_PORT_W-1:0]  new_id;
    logic                  all_present;
    logic [CNT_PORT_W-1:0] entity_count;
    status_t               status;

    modport source (output valid, output new_id, output all_present, output entity_count,
                    output status, input ready);
    modport sink   (input valid, input new_id, input all_present, input entity_count,
                    input status, output ready);
endinterface

[design/entity_id_allocator_with_masks_core.sv]
// entity_id_allocator_with_masks_core: top level of the entity id allocator
// depends on: eida_pkg, eida_req_if, eida_rsp_if, eida_ctrl, eida_dp
//
// usage
//   req carries one command per transaction (create, delete, check mask,
//   set or clear a component bit) with its id, query mask and component
//   index; rsp returns one result per command: new id, check answer,
//   high-water count and status code.
//   a request is taken in the idle state, the mask table and the free stack
//   are read into their registered outputs at that edge, and the commit
//   state does the read-modify-write and loads the result register.
//   a new request is not taken until the previous one has committed, since
//   the registered read of the mask ram is followed by its write-back.
//   a new request is taken while the previous result still waits on rsp;
//   if rsp stays stalled the commit cycle holds until the result is taken.
//   reset clears the stack pointer, the high-water count, the sequencer and
//   the result valid flag; the ram contents are not cleared and need no
//   clearing pass, since only entries written earlier are ever used.

module entity_id_allocator_with_masks_core import eida_pkg::*; #(
    parameter int MAX_ENTITIES    = MAX_ENTITIES_DEF,
    parameter int COMPONENT_KINDS = COMPONENT_KINDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    eida_req_if.sink   req,
    eida_rsp_if.source rsp
);

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    // sequencer
    eida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // storage and command evaluation
    eida_dp #(
        .MAX_ENTITIES    (MAX_ENTITIES),
        .COMPONENT_KINDS (COMPONENT_KINDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .cmd              (req.cmd),
        .entity_id        (req.entity_id),
        .query_mask       (req.query_mask),
        .component_index  (req.component_index),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_new_id       (rsp.new_id),
        .rsp_all_present  (rsp.all_present),
        .rsp_entity_count (rsp.entity_count),
        .rsp_status       (rsp.status)
    );

endmodule

[design/eida_ram.sv]
// eida_ram: generic single-write, single-read ram with registered read data
// depends on: nothing

module eida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/eida_ctrl.sv]
// eida_ctrl: two-state sequencer, read phase then commit phase
// depends on: eida_pkg

module eida_ctrl import eida_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                ctrl.accept = req_valid;
            end
            S_EXEC:
            begin
                ctrl.commit = !stat.out_stall;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/eida_dp.sv]
// eida_dp: command registers, mask table, free stack, counters and result register
// depends on: eida_pkg, eida_ram

module eida_dp import eida_pkg::*; #(
    parameter int MAX_ENTITIES    = MAX_ENTITIES_DEF,
    parameter int COMPONENT_KINDS = COMPONENT_KINDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             ctrl,
    output dp_status_t            stat,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [ID_PORT_W-1:0]  entity_id,
    input  logic [QMASK_W-1:0]    query_mask,
    input  logic [COMP_W-1:0]     component_index,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [ID_PORT_W-1:0]  rsp_new_id,
    output logic                  rsp_all_present,
    output logic [CNT_PORT_W-1:0] rsp_entity_count,
    output status_t               rsp_status
);

    localparam int ID_W   = $clog2(MAX_ENTITIES);
    localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
    localparam int MASK_W = COMPONENT_KINDS;
    localparam int QW     = (MASK_W > QMASK_W) ? MASK_W : QMASK_W;
    localparam int CMP_W  = (CNT_W > ID_PORT_W) ? CNT_W : ID_PORT_W;

    // captured transaction
    logic [CMD_W-1:0]     cmd_reg;
    logic [ID_PORT_W-1:0] id_reg;
    logic [QMASK_W-1:0]   query_reg;
    logic [COMP_W-1:0]    comp_reg;

    logic [CNT_W-1:0] free_top_reg, free_top_next;
    logic [CNT_W-1:0] hw_reg, hw_next;

    logic                  out_valid_reg;
    logic [ID_PORT_W-1:0]  new_id_reg;
    logic                  present_reg;
    logic [CNT_PORT_W-1:0] count_reg;
    status_t               status_reg;

    // memory ports
    logic              mask_wr, mask_we;
    logic [ID_W-1:0]   mask_waddr;
    logic [MASK_W-1:0] mask_wdata;
    logic [MASK_W-1:0] mask_rd;
    logic              stack_wr, stack_we;
    logic [ID_W-1:0]   stack_waddr;
    logic [ID_W-1:0]   stack_wdata;
    logic [ID_W-1:0]   stack_raddr;
    logic [ID_W-1:0]   stack_rd;

    // command evaluation
    logic              id_ok;
    logic              comp_ok;
    logic [ID_W-1:0]   id_addr;
    logic [MASK_W-1:0] comp_bit;
    logic [ID_W-1:0]   new_id_val;
    logic              present_val;
    status_t           status_val;

    eida_ram #(.WIDTH(MASK_W), .DEPTH(MAX_ENTITIES)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (ctrl.accept),
        .raddr (ID_W'(entity_id)),
        .rdata (mask_rd)
    );

    eida_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTITIES)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (ctrl.accept),
        .raddr (stack_raddr),
        .rdata (stack_rd)
    );

    // top of stack read address, only used when the stack is not empty
    assign stack_raddr = ID_W'(free_top_reg - CNT_W'(1));

    // capture the transaction at accept
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg   <= cmd;
            id_reg    <= entity_id;
            query_reg <= query_mask;
            comp_reg  <= component_index;
        end
    end

    assign id_ok    = CMP_W'(id_reg) < CMP_W'(hw_reg);
    assign comp_ok  = 32'(comp_reg) < COMPONENT_KINDS;
    assign id_addr  = ID_W'(id_reg);
    assign comp_bit = MASK_W'(1) << comp_reg;

    // command decode and read-modify-write
    always_comb
    begin
        mask_wr       = 1'b0;
        mask_waddr    = id_addr;
        mask_wdata    = '0;
        stack_wr      = 1'b0;
        stack_waddr   = ID_W'(free_top_reg);
        stack_wdata   = id_addr;
        free_top_next = free_top_reg;
        hw_next       = hw_reg;
        new_id_val    = '0;
        present_val   = 1'b0;
        status_val    = ST_OK;
        unique case (cmd_reg) inside
            CMD_CREATE:
            begin
                if (free_top_reg != '0)
                begin
                    new_id_val    = stack_rd;
                    free_top_next = free_top_reg - CNT_W'(1);
                    mask_wr       = 1'b1;
                    mask_waddr    = stack_rd;
                end
                else if (hw_reg != CNT_W'(MAX_ENTITIES))
                begin
                    new_id_val = ID_W'(hw_reg);
                    hw_next    = hw_reg + CNT_W'(1);
                    mask_wr    = 1'b1;
                    mask_waddr = ID_W'(hw_reg);
                end
                else
                begin
                    status_val = ST_NONE_LEFT;
                end
            end
            CMD_DELETE:
            begin
                if (!id_ok)
                begin
                    status_val = ST_BAD_ID;
                end
                else if (free_top_reg == CNT_W'(MAX_ENTITIES))
                begin
                    status_val = ST_STACK_FULL;
                end
                else
                begin
                    mask_wr       = 1'b1;
                    stack_wr      = 1'b1;
                    free_top_next = free_top_reg + CNT_W'(1);
                end
            end
            CMD_CHECK:
            begin
                if (!id_ok)
                begin
                    status_val = ST_BAD_ID;
                end
                else
                begin
                    present_val = (QW'(mask_rd) & QW'(query_reg)) == QW'(query_reg);
                end
            end
            CMD_SET, CMD_CLEAR:
            begin
                if (!id_ok)
                begin
                    status_val = ST_BAD_ID;
                end
                else if (comp_ok)
                begin
                    mask_wr    = 1'b1;
                    mask_wdata = (cmd_reg == CMD_SET) ? (mask_rd | comp_bit)
                                                      : (mask_rd & ~comp_bit);
                end
            end
            default:
            begin
                status_val = ST_OK;
            end
        endcase
    end

    assign mask_we  = ctrl.commit && mask_wr;
    assign stack_we = ctrl.commit && stack_wr;

    // stack pointer and high-water count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg <= '0;
            hw_reg       <= '0;
        end
        else if (ctrl.commit)
        begin
            free_top_reg <= free_top_next;
            hw_reg       <= hw_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            new_id_reg  <= ID_PORT_W'(new_id_val);
            present_reg <= present_val;
            count_reg   <= CNT_PORT_W'(hw_next);
            status_reg  <= status_val;
        end
    end

    assign stat.out_stall   = out_valid_reg && !rsp_ready;
    assign rsp_valid        = out_valid_reg;
    assign rsp_new_id       = new_id_reg;
    assign rsp_all_present  = present_reg;
    assign rsp_entity_count = count_reg;
    assign rsp_status       = status_reg;

endmodule

[design/eida_chk.sv]
// eida_chk: port-level checks of the entity id allocator, bound to the top level
// depends on: eida_pkg, entity_id_allocator_with_masks_core

module eida_chk import eida_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [ID_PORT_W-1:0]  rsp_new_id,
    input logic                  rsp_all_present,
    input logic [CNT_PORT_W-1:0] rsp_entity_count,
    input status_t               rsp_status
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_id)
            && $stable(rsp_status) && $stable(rsp_entity_count))
        else $error("result changed while stalled");

    // no request is taken right after one is taken
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in back-to-back cycles");

    // a rising result valid comes from a request that passed the exec state without a stall
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a matching request");

    // a nonzero id comes only from a successful create
    a_new_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_new_id != '0) |-> (rsp_status == ST_OK) && !rsp_all_present)
        else $error("nonzero id with failure status or check answer");

    // a positive check answer carries no id and no failure
    a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_all_present |-> (rsp_status == ST_OK) && (rsp_new_id == '0))
        else $error("check answer with failure status or id");

endmodule

bind entity_id_allocator_with_masks_core eida_chk u_eida_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_new_id       (rsp.new_id),
    .rsp_all_present  (rsp.all_present),
    .rsp_entity_count (rsp.entity_count),
    .rsp_status       (rsp.status)
);

[tb/eida_result_checker.sv]
`timescale 1ns / 100ps
// eida_result_checker: predicts each result of the entity id allocator and compares
// it with the result channel; hands a failure count and run statistics to the tb top
// depends on: eida_pkg

module eida_result_checker import eida_pkg::*; #(
    parameter int MAX_IDS = MAX_ENTITIES_DEF,
    parameter int KINDS   = COMPONENT_KINDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [ID_PORT_W-1:0]  entity_id,
    input  logic [QMASK_W-1:0]    query_mask,
    input  logic [COMP_W-1:0]     component_index,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  logic [ID_PORT_W-1:0]  new_id,
    input  logic                  all_present,
    input  logic [CNT_PORT_W-1:0] entity_count,
    input  status_t               status,
    output int                    outstanding,
    output int                    fail_count,
    output int                    results_seen,
    output int                    ok_hits,
    output int                    none_left_hits,
    output int                    bad_id_hits,
    output int                    full_hits
);

    typedef struct packed {
        logic [ID_PORT_W-1:0]  new_id;
        logic                  all_present;
        logic [CNT_PORT_W-1:0] entity_count;
        status_t               status;
    } alloc_result_t;

    // shadow copy of the allocator state
    logic [QMASK_W-1:0]   comp_masks [MAX_IDS];
    logic [ID_PORT_W-1:0] free_ids   [MAX_IDS];
    int unsigned          free_depth = 0;
    int unsigned          high_water = 0;

    alloc_result_t owed_results [$];
    int            mismatches = 0;
    int            seen       = 0;
    int            hits [4]   = '{0, 0, 0, 0};

    // apply one command to the shadow state and return the result it owes
    function automatic alloc_result_t run_command(logic [CMD_W-1:0] c,
                                                  logic [ID_PORT_W-1:0] id,
                                                  logic [QMASK_W-1:0] qm,
                                                  logic [COMP_W-1:0] ci);
        alloc_result_t r;
        logic          id_known;
        r = '0;
        r.status = ST_OK;
        id_known = (id < high_water);
        case (c)
            CMD_CREATE: begin
                if (free_depth > 0) begin
                    free_depth--;
                    r.new_id = free_ids[free_depth];
                    comp_masks[r.new_id] = '0;
                end else if (high_water < MAX_IDS) begin
                    r.new_id = ID_PORT_W'(high_water);
                    comp_masks[high_water] = '0;
                    high_water++;
                end else begin
                    r.status = ST_NONE_LEFT;
                end
            end
            CMD_DELETE: begin
                if (!id_known) begin
                    r.status = ST_BAD_ID;
                end else if (free_depth >= MAX_IDS) begin
                    r.status = ST_STACK_FULL;
                end else begin
                    comp_masks[id] = '0;
                    free_ids[free_depth] = id;
                    free_depth++;
                end
            end
            CMD_CHECK: begin
                if (!id_known)
                    r.status = ST_BAD_ID;
                else
                    r.all_present = ((comp_masks[id] & qm) == qm);
            end
            CMD_SET, CMD_CLEAR: begin
                if (!id_known)
                    r.status = ST_BAD_ID;
                else if (ci < KINDS)
                    comp_masks[id][ci] = (c == CMD_SET);
            end
            default: ;
        endcase
        r.entity_count = CNT_PORT_W'(high_water);
        return r;
    endfunction

    task automatic report(string what, alloc_result_t e, alloc_result_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected id %0d present %0d count %0d status %0d,",
                     $time, what, e.new_id, e.all_present, e.entity_count, e.status,
                     " got id %0d present %0d count %0d status %0d",
                     a.new_id, a.all_present, a.entity_count, a.status);
    endtask

    // pop and compare results, then predict for newly accepted commands
    always @(posedge clk or negedge rst_n) begin
        alloc_result_t act;
        alloc_result_t exp_r;
        if (!rst_n) begin
            free_depth = 0;
            high_water = 0;
            owed_results.delete();
        end else begin
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
                act.new_id       = new_id;
                act.all_present  = all_present;
                act.entity_count = entity_count;
                act.status       = status;
                seen++;
                if (owed_results.size() == 0) begin
                    report("result with nothing owed", '0, act);
                end else begin
                    exp_r = owed_results.pop_front();
                    hits[exp_r.status]++;
                    if (act.new_id !== exp_r.new_id || act.all_present !== exp_r.all_present ||
                        act.entity_count !== exp_r.entity_count || act.status !== exp_r.status)
                        report("mismatch", exp_r, act);
                end
            end
            if (req_valid === 1'b1 && req_ready === 1'b1)
                owed_results.insert(owed_results.size(),
                                    run_command(cmd, entity_id, query_mask, component_index));
        end
        outstanding    <= owed_results.size();
        fail_count     <= mismatches;
        results_seen   <= seen;
        ok_hits        <= hits[ST_OK];
        none_left_hits <= hits[ST_NONE_LEFT];
        bad_id_hits    <= hits[ST_BAD_ID];
        full_hits      <= hits[ST_STACK_FULL];
    end

endmodule

[tb/entity_id_allocator_with_masks_core_tb.sv]
`timescale 1ns / 100ps
// entity_id_allocator_with_masks_core_tb: drives commands into the entity id allocator
// with random idling on both channels and gives the verdict from the result checker
// depends on: eida_pkg, eida_req_if, eida_rsp_if, eida_result_checker, the block

module entity_id_allocator_with_masks_core_tb import eida_pkg::*;;

    localparam int MAX_IDS      = MAX_ENTITIES_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    logic clk;
    logic rst_n;

    eida_req_if req_if();
    eida_rsp_if rsp_if();

    int outstanding, fail_count, results_seen;
    int ok_hits, none_left_hits, bad_id_hits, full_hits;
    int items_sent   = 0;
    int creates_sent = 0;
    int deletes_sent = 0;
    int hold_trig    = 0;
    int hold_done    = 0;
    int cycle_cnt    = 0;
    bit no_idle      = 1'b0;

    entity_id_allocator_with_masks_core #(
        .MAX_ENTITIES   (MAX_IDS),
        .COMPONENT_KINDS(COMPONENT_KINDS_DEF)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    eida_result_checker #(
        .MAX_IDS(MAX_IDS),
        .KINDS  (COMPONENT_KINDS_DEF)
    ) result_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_if.valid),
        .req_ready      (req_if.ready),
        .cmd            (req_if.cmd),
        .entity_id      (req_if.entity_id),
        .query_mask     (req_if.query_mask),
        .component_index(req_if.component_index),
        .rsp_valid      (rsp_if.valid),
        .rsp_ready      (rsp_if.ready),
        .new_id         (rsp_if.new_id),
        .all_present    (rsp_if.all_present),
        .entity_count   (rsp_if.entity_count),
        .status         (rsp_if.status),
        .outstanding    (outstanding),
        .fail_count     (fail_count),
        .results_seen   (results_seen),
        .ok_hits        (ok_hits),
        .none_left_hits (none_left_hits),
        .bad_id_hits    (bad_id_hits),
        .full_hits      (full_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send_cmd(logic [CMD_W-1:0] c, int id, int qm, int ci);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.cmd             <= c;
        req_if.entity_id       <= ID_PORT_W'(id);
        req_if.query_mask      <= QMASK_W'(qm);
        req_if.component_index <= COMP_W'(ci);
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        if (c == CMD_CREATE)
            creates_sent++;
        if (c == CMD_DELETE)
            deletes_sent++;
    endtask

    // stop offering until every owed result has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_trig != hold_done)
            begin
                hold_done  = hold_trig;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int               r;
        int               id;
        int               id_hi;
        int               qm;
        logic [CMD_W-1:0] c;

        rst_n                  = 1'b0;
        req_if.valid           = 1'b0;
        req_if.cmd             = CMD_CREATE;
        req_if.entity_id       = '0;
        req_if.query_mask      = '0;
        req_if.component_index = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing handed out yet: every id is unknown, reserved codes do nothing
        send_cmd(CMD_CHECK, 0, 8'hff, 0);
        send_cmd(CMD_DELETE, 0, 0, 0);
        send_cmd(CMD_SET, 0, 0, 7);
        send_cmd(CMD_CLEAR, 0, 0, 0);
        send_cmd(CMD_RSVD_FIRST, 0, 0, 0);
        send_cmd(CMD_RSVD_MID, 1023, 8'hff, 7);
        send_cmd(CMD_RSVD_LAST, 512, 8'h55, 3);
        // fresh ids, then bit set/clear and checks on id 1
        send_cmd(CMD_CREATE, 1023, 8'hff, 7);
        send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_SET, 1, 0, 0);
        send_cmd(CMD_SET, 1, 0, 7);
        send_cmd(CMD_CHECK, 1, 8'h81, 0);
        send_cmd(CMD_CHECK, 1, 8'hff, 0);
        send_cmd(CMD_CHECK, 1, 8'h00, 0);
        send_cmd(CMD_CLEAR, 1, 0, 0);
        send_cmd(CMD_CHECK, 1, 8'h81, 0);
        // double delete pushes id 1 twice, so two creates both hand it out
        send_cmd(CMD_DELETE, 1, 0, 0);
        send_cmd(CMD_DELETE, 1, 0, 0);
        send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_CHECK, 1, 8'h80, 0);
        // top of the id range is still unknown
        send_cmd(CMD_CHECK, 1023, 8'h01, 0);
        send_cmd(CMD_SET, 1023, 0, 7);
        wait_drained();

        // random mix, ids mostly among those already handed out
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 150)
                hold_trig++;
            no_idle = (n >= 500 && n < 600);
            r = $urandom_range(0, 99);
            if (r < 22)
                c = CMD_CREATE;
            else if (r < 34)
                c = CMD_DELETE;
            else if (r < 58)
                c = CMD_CHECK;
            else if (r < 78)
                c = CMD_SET;
            else if (r < 94)
                c = CMD_CLEAR;
            else
                c = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
            id_hi = (creates_sent > MAX_IDS - 1) ? MAX_IDS - 1 : creates_sent;
            r = $urandom_range(0, 99);
            if (r < 45)
                id = $urandom_range(0, (id_hi < 7) ? id_hi : 7);
            else if (r < 85)
                id = $urandom_range(0, id_hi);
            else
                id = $urandom_range(0, MAX_IDS - 1);
            r = $urandom_range(0, 99);
            if (r < 40)
                qm = 1 << $urandom_range(0, QMASK_W - 1);
            else if (r < 50)
                qm = 0;
            else
                qm = $urandom_range(0, (1 << QMASK_W) - 1);
            send_cmd(c, id, qm, $urandom_range(0, (1 << COMP_W) - 1));
        end
        no_idle = 1'b0;
        wait_drained();

        // pop a few back and check random ids
        for (int n = 0; n < 12; n++)
        begin
            send_cmd(CMD_CREATE, 0, 0, 0);
            send_cmd(CMD_CHECK, $urandom_range(0, MAX_IDS - 1),
                     $urandom_range(0, (1 << QMASK_W) - 1), 0);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d commands (%0d creates, %0d deletes), %0d results checked",
                 items_sent, creates_sent, deletes_sent, results_seen);
        $display("status seen: ok %0d, none left %0d, unknown id %0d, stack full %0d",
                 ok_hits, none_left_hits, bad_id_hits, full_hits);
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
design/eida_pkg.sv
design/eida_req_if.sv
design/eida_rsp_if.sv
design/eida_ram.sv
design/eida_ctrl.sv
design/eida_dp.sv
design/entity_id_allocator_with_masks_core.sv
design/eida_chk.sv
tb/eida_result_checker.sv
tb/entity_id_allocator_with_masks_core_tb.sv
